// ----- hw/rtl/ps2mpt_pkg.sv -----
`default_nettype none

package ps2mpt_pkg;

  localparam int unsigned FontWidth  = 8;
  localparam int unsigned FontHeight = 16;
  localparam int unsigned CoordBits  = 12;

  localparam int unsigned CfgDataW = 12;
  localparam int unsigned ScaleW   = 5;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned OutW     = 12;

  localparam int unsigned LimW = (CoordBits > CfgDataW) ? CoordBits : CfgDataW;
  localparam int unsigned SumW = ((CoordBits > 13) ? CoordBits : 13) + 2;
  localparam int unsigned StepW = 14;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [ByteW-1:0]     byte_t;

  typedef enum logic [1:0] {
    CfgMotionScale = 2'd0,
    CfgMaxPixelX   = 2'd1,
    CfgMaxPixelY   = 2'd2
  } cfg_idx_e;

  localparam int unsigned HdrLeftBit  = 0;
  localparam int unsigned HdrOneBit   = 3;
  localparam int unsigned HdrXSignBit = 4;
  localparam int unsigned HdrYSignBit = 5;
  localparam int unsigned HdrXOvfBit  = 6;
  localparam int unsigned HdrYOvfBit  = 7;

  localparam logic signed [ByteW-1:0] DeltaPos = 8'sd127;
  localparam logic signed [ByteW-1:0] DeltaNeg = -8'sd127;

  localparam logic [ScaleW-1:0] ScaleMin   = 5'd1;
  localparam logic [ScaleW-1:0] ScaleMax   = 5'd16;
  localparam logic [ScaleW-1:0] ScaleReset = 5'd1;

  localparam logic [CfgDataW-1:0] MaxXReset = 12'd639;
  localparam logic [CfgDataW-1:0] MaxYReset = 12'd399;

  localparam coord_t CoordMax  = {CoordBits{1'b1}};
  localparam coord_t PosXReset = coord_t'(40 * FontWidth);
  localparam coord_t PosYReset = coord_t'(12 * FontHeight);

  function automatic coord_t axis_limit(logic [CfgDataW-1:0] max_cfg);
    coord_t lim;
    if (LimW'(max_cfg) < LimW'(CoordMax)) begin
      lim = coord_t'(max_cfg);
    end else begin
      lim = CoordMax;
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ps2mpt_move.sv -----
`default_nettype none

module ps2mpt_move (
  input  ps2mpt_pkg::coord_t             pos_i,
  input  logic signed [ps2mpt_pkg::ByteW-1:0] delta_i,
  input  logic [ps2mpt_pkg::ScaleW-1:0]  scale_i,
  input  logic                           negate_i,
  input  ps2mpt_pkg::coord_t             limit_i,
  output ps2mpt_pkg::coord_t             pos_o
);
  import ps2mpt_pkg::*;

  logic signed [ScaleW:0]   scale_s;
  logic signed [StepW-1:0]  prod;
  logic signed [StepW-1:0]  step;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   lim_s;

  assign scale_s = signed'({1'b0, scale_i});
  assign prod    = StepW'(delta_i) * StepW'(scale_s);
  assign step    = negate_i ? -prod : prod;
  assign sum     = SumW'(signed'({1'b0, pos_i})) + SumW'(step);
  assign lim_s   = SumW'(signed'({1'b0, limit_i}));

  always_comb begin
    if (sum < 0) begin
      pos_o = '0;
    end else if (sum > lim_s) begin
      pos_o = limit_i;
    end else begin
      pos_o = coord_t'(sum);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ps2_mouse_pointer_tracker.sv -----
// PS/2 mouse pointer tracker. Takes one mouse byte per cycle on the input
// channel while not stalled and frames bytes into 3-byte packets; a first
// byte without bit 3 set is dropped. Each complete packet yields one output
// word with the decoded deltas, left button, clamped pixel position and text
// cell position. A byte passes an input register and then the decode, scale
// and clamp logic into the output register, which takes a packet's word as
// its third byte leaves the input register; the sustained rate is one byte
// per cycle, limited only by the output stall. Configuration (scale, x and y
// limits) is always ready and should be written while no packet is pending.
`default_nettype none

module ps2_mouse_pointer_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [1:0]                          cfg_index_i,
  input  logic [ps2mpt_pkg::CfgDataW-1:0]     cfg_data_i,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [ps2mpt_pkg::ByteW-1:0]        rx_byte_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ps2mpt_pkg::ByteW-1:0]        header_byte_o,
  output logic signed [ps2mpt_pkg::ByteW-1:0] delta_x_o,
  output logic signed [ps2mpt_pkg::ByteW-1:0] delta_y_o,
  output logic                                left_pressed_o,
  output logic [ps2mpt_pkg::OutW-1:0]         pointer_x_o,
  output logic [ps2mpt_pkg::OutW-1:0]         pointer_y_o,
  output logic [ps2mpt_pkg::OutW-1:0]         cell_col_o,
  output logic [ps2mpt_pkg::OutW-1:0]         cell_row_o
);
  import ps2mpt_pkg::*;

  logic [ScaleW-1:0]   scale_q;
  logic [CfgDataW-1:0] max_x_q;
  logic [CfgDataW-1:0] max_y_q;

  logic  in_valid_q;
  byte_t in_byte_q;

  logic [1:0] cnt_q;
  byte_t      hdr_q;
  byte_t      dx_q;
  coord_t     pos_x_q;
  coord_t     pos_y_q;

  logic out_valid_q;
  logic out_free;
  logic s1_adv;
  logic pkt_done;

  logic signed [ByteW-1:0] dx;
  logic signed [ByteW-1:0] dy;
  logic [ScaleW-1:0]       scale_eff;
  coord_t                  pos_x_d;
  coord_t                  pos_y_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      max_x_q <= MaxXReset;
      max_y_q <= MaxYReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgMotionScale: scale_q <= cfg_data_i[ScaleW-1:0];
        CfgMaxPixelX:   max_x_q <= cfg_data_i;
        CfgMaxPixelY:   max_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !out_free;
  assign s1_adv     = in_valid_q && out_free;
  assign pkt_done   = s1_adv && (cnt_q == 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_comb begin
    if (hdr_q[HdrXOvfBit]) begin
      dx = hdr_q[HdrXSignBit] ? DeltaNeg : DeltaPos;
    end else begin
      dx = signed'(dx_q);
    end
    if (hdr_q[HdrYOvfBit]) begin
      dy = hdr_q[HdrYSignBit] ? DeltaNeg : DeltaPos;
    end else begin
      dy = signed'(in_byte_q);
    end
    if (scale_q < ScaleMin) begin
      scale_eff = ScaleMin;
    end else if (scale_q > ScaleMax) begin
      scale_eff = ScaleMax;
    end else begin
      scale_eff = scale_q;
    end
  end

  ps2mpt_move u_move_x (
    .pos_i    (pos_x_q),
    .delta_i  (dx),
    .scale_i  (scale_eff),
    .negate_i (1'b0),
    .limit_i  (axis_limit(max_x_q)),
    .pos_o    (pos_x_d)
  );

  ps2mpt_move u_move_y (
    .pos_i    (pos_y_q),
    .delta_i  (dy),
    .scale_i  (scale_eff),
    .negate_i (1'b1),
    .limit_i  (axis_limit(max_y_q)),
    .pos_o    (pos_y_d)
  );

  // advance packet framing and update the pointer position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= 2'd0;
      hdr_q   <= '0;
      dx_q    <= '0;
      pos_x_q <= PosXReset;
      pos_y_q <= PosYReset;
    end else if (s1_adv) begin
      case (cnt_q)
        2'd0: begin
          if (in_byte_q[HdrOneBit]) begin
            hdr_q <= in_byte_q;
            cnt_q <= 2'd1;
          end
        end
        2'd1: begin
          dx_q  <= in_byte_q;
          cnt_q <= 2'd2;
        end
        2'd2: begin
          cnt_q   <= 2'd0;
          pos_x_q <= pos_x_d;
          pos_y_q <= pos_y_d;
        end
        default: cnt_q <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= pkt_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_done) begin
      header_byte_o  <= hdr_q;
      delta_x_o      <= dx;
      delta_y_o      <= dy;
      left_pressed_o <= hdr_q[HdrLeftBit];
      pointer_x_o    <= OutW'(pos_x_d);
      pointer_y_o    <= OutW'(pos_y_d);
      cell_col_o     <= OutW'(pos_x_d / FontWidth);
      cell_row_o     <= OutW'(pos_y_d / FontHeight);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ps2mpt_checker.sv -----
`default_nettype none

module ps2mpt_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [ps2mpt_pkg::ByteW-1:0]        header_byte_o,
  input logic signed [ps2mpt_pkg::ByteW-1:0] delta_x_o,
  input logic                                left_pressed_o,
  input logic [ps2mpt_pkg::OutW-1:0]         pointer_x_o,
  input logic [ps2mpt_pkg::OutW-1:0]         cell_col_o
);
  import ps2mpt_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pointer_x_o) && $stable(header_byte_o))
    else $error("output word changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> header_byte_o[HdrOneBit] &&
                    (left_pressed_o == header_byte_o[HdrLeftBit]))
    else $error("header framing or button decode wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && header_byte_o[HdrXOvfBit] |->
      (delta_x_o == (header_byte_o[HdrXSignBit] ? DeltaNeg : DeltaPos)))
    else $error("x overflow not forced");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cell_col_o == OutW'(pointer_x_o / FontWidth))
    else $error("text column does not match pointer x");

endmodule

bind ps2_mouse_pointer_tracker ps2mpt_checker u_checker (.*);

`default_nettype wire
